// ===== rtl/tpg_pkg.sv =====
`default_nettype none

package tpg_pkg;

	// Storage geometry
	localparam int RAM_AW  = 13;
	localparam int BANK_AW = 12;
	localparam int PROM_AW = 5;

	// Command codes
	localparam logic [1:0] ACT_WR_RAM  = 2'd0;
	localparam logic [1:0] ACT_WR_PROM = 2'd1;
	localparam logic [1:0] ACT_RENDER  = 2'd2;

	// Address map
	localparam logic [RAM_AW-1:0] MAP_BASE     = 13'h0800;
	localparam logic [RAM_AW-1:0] PATTERN_BASE = 13'h1000;
	localparam logic [RAM_AW-1:0] TILE_BYTES   = 13'h0010;

	// Resistor weights of the colour DAC
	localparam logic [7:0] WEIGHT0 = 8'h21;
	localparam logic [7:0] WEIGHT1 = 8'h47;
	localparam logic [7:0] WEIGHT2 = 8'h97;

	typedef struct packed {
		logic [1:0]        action;
		logic [RAM_AW-1:0] ram_address;
		logic [7:0]        write_data;
		logic [7:0]        pixel_x;
		logic [7:0]        pixel_y;
	} cmd_t;

	typedef struct packed {
		logic [4:0] palette_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// After the tile map / attribute fetch
	typedef struct packed {
		logic              valid;
		logic [1:0]        action;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        data;
		logic [7:0]        code;
		logic [2:0]        attr;
		logic [2:0]        x_lo;
		logic [2:0]        y_lo;
	} map_stage_t;

	// After the pattern fetch
	typedef struct packed {
		logic               valid;
		logic [1:0]         action;
		logic [PROM_AW-1:0] prom_addr;
		logic [7:0]         data;
		logic [7:0]         pattern;
		logic [2:0]         attr;
		logic [1:0]         sub;
	} pat_stage_t;

	// After the colour PROM lookup; valid only for rendered pixels
	typedef struct packed {
		logic               valid;
		logic [PROM_AW-1:0] palette_index;
		logic [7:0]         color;
	} pal_stage_t;

	// Three-resistor level; all three weights sum to 8'hFF, so it fits in 8 bits
	function automatic logic [7:0] level3(input logic [2:0] b);
		logic [7:0] sum;
		sum = (b[0] ? WEIGHT0 : 8'd0) + (b[1] ? WEIGHT1 : 8'd0) + (b[2] ? WEIGHT2 : 8'd0);
		return sum;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tpg_stream_if.sv =====
`default_nettype none

interface tpg_stream_if #(parameter type payload_t = logic [7:0]);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/tpg_map_fetch.sv =====
`default_nettype none

module tpg_map_fetch (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_valid,
	input  wire tpg_pkg::cmd_t     in_cmd,
	output tpg_pkg::map_stage_t    map_s2
);
	import tpg_pkg::*;

	// Lower half of video RAM: attributes and tile map
	logic [7:0] bank0 [0:(1<<BANK_AW)-1];

	logic [5:0]        col;
	logic [4:0]        row;
	logic [RAM_AW-1:0] code_addr;
	logic [RAM_AW-1:0] attr_addr;

	logic               valid_s1;
	logic [1:0]         action_s1;
	logic [RAM_AW-1:0]  addr_s1;
	logic [7:0]         data_s1;
	logic [2:0]         x_lo_s1;
	logic [2:0]         y_lo_s1;
	logic [BANK_AW-1:0] code_idx_s1;
	logic [BANK_AW-1:0] attr_idx_s1;

	logic               valid_s2;
	logic [1:0]         action_s2;
	logic [RAM_AW-1:0]  addr_s2;
	logic [7:0]         data_s2;
	logic [2:0]         x_lo_s2;
	logic [2:0]         y_lo_s2;
	logic [7:0]         code_s2;
	logic [2:0]         attr_s2;

	// Tile column is (x+256)>>3, always 32..63
	assign col       = {1'b1, in_cmd.pixel_x[7:3]};
	assign row       = in_cmd.pixel_y[7:3];
	assign code_addr = MAP_BASE | {2'b00, row, col};
	assign attr_addr = {3'b000, row[4:1], col};

	// Stage 1: capture command, address precompute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s1   <= in_cmd.action;
			addr_s1     <= in_cmd.ram_address;
			data_s1     <= in_cmd.write_data;
			x_lo_s1     <= in_cmd.pixel_x[2:0];
			y_lo_s1     <= in_cmd.pixel_y[2:0];
			code_idx_s1 <= code_addr[BANK_AW-1:0];
			attr_idx_s1 <= attr_addr[BANK_AW-1:0];
			action_s2   <= action_s1;
			addr_s2     <= addr_s1;
			data_s2     <= data_s1;
			x_lo_s2     <= x_lo_s1;
			y_lo_s2     <= y_lo_s1;
		end
	end

	// Stage 2: bank 0 write port and two read ports
	always_ff @(posedge clk) begin
		if (adv) begin
			if (valid_s1 && action_s1 == ACT_WR_RAM && !addr_s1[RAM_AW-1])
				bank0[addr_s1[BANK_AW-1:0]] <= data_s1;
			code_s2 <= bank0[code_idx_s1];
			attr_s2 <= bank0[attr_idx_s1][2:0];
		end
	end

	assign map_s2 = '{valid:  valid_s2,
	                  action: action_s2,
	                  addr:   addr_s2,
	                  data:   data_s2,
	                  code:   code_s2,
	                  attr:   attr_s2,
	                  x_lo:   x_lo_s2,
	                  y_lo:   y_lo_s2};

endmodule

`default_nettype wire

// ===== rtl/tpg_pattern_fetch.sv =====
`default_nettype none

module tpg_pattern_fetch (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire tpg_pkg::map_stage_t map_s2,
	output tpg_pkg::pat_stage_t      pat_s3
);
	import tpg_pkg::*;

	// Upper half of video RAM: tile patterns
	logic [7:0] bank1 [0:(1<<BANK_AW)-1];

	logic [RAM_AW-1:0] pat_addr;

	logic               valid_s3;
	logic [1:0]         action_s3;
	logic [PROM_AW-1:0] prom_addr_s3;
	logic [7:0]         data_s3;
	logic [7:0]         pattern_s3;
	logic [2:0]         attr_s3;
	logic [1:0]         sub_s3;

	// 16 bytes per tile, two bytes per line, half-tile select from x bit 2
	assign pat_addr = (({5'd0, map_s2.code} * TILE_BYTES) + PATTERN_BASE)
	                | {9'd0, map_s2.y_lo, map_s2.x_lo[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (adv)
			valid_s3 <= map_s2.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s3    <= map_s2.action;
			prom_addr_s3 <= map_s2.addr[PROM_AW-1:0];
			data_s3      <= map_s2.data;
			attr_s3      <= map_s2.attr;
			sub_s3       <= map_s2.x_lo[1:0];
		end
	end

	// Stage 3: bank 1 write and pattern read
	always_ff @(posedge clk) begin
		if (adv) begin
			if (map_s2.valid && map_s2.action == ACT_WR_RAM && map_s2.addr[RAM_AW-1])
				bank1[map_s2.addr[BANK_AW-1:0]] <= map_s2.data;
			pattern_s3 <= bank1[pat_addr[BANK_AW-1:0]];
		end
	end

	assign pat_s3 = '{valid:     valid_s3,
	                  action:    action_s3,
	                  prom_addr: prom_addr_s3,
	                  data:      data_s3,
	                  pattern:   pattern_s3,
	                  attr:      attr_s3,
	                  sub:       sub_s3};

endmodule

`default_nettype wire

// ===== rtl/tpg_palette.sv =====
`default_nettype none

module tpg_palette (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire tpg_pkg::pat_stage_t pat_s3,
	output tpg_pkg::pal_stage_t      pal_s4
);
	import tpg_pkg::*;

	logic [7:0] prom [0:(1<<PROM_AW)-1];

	logic               pen0;
	logic               pen1;
	logic [PROM_AW-1:0] idx;

	logic               valid_s4;
	logic [PROM_AW-1:0] idx_s4;
	logic [7:0]         color_s4;

	// Pen bits at 3-s and 7-s; 3-s is the complement of s
	assign pen0 = pat_s3.pattern[{1'b0, ~pat_s3.sub}];
	assign pen1 = pat_s3.pattern[{1'b1, ~pat_s3.sub}];
	assign idx  = {pat_s3.attr, pen1, pen0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (adv)
			valid_s4 <= pat_s3.valid && pat_s3.action == ACT_RENDER;
	end

	// Stage 4: PROM write and colour read
	always_ff @(posedge clk) begin
		if (adv) begin
			if (pat_s3.valid && pat_s3.action == ACT_WR_PROM)
				prom[pat_s3.prom_addr] <= pat_s3.data;
			color_s4 <= prom[idx];
			idx_s4   <= idx;
		end
	end

	assign pal_s4 = '{valid: valid_s4, palette_index: idx_s4, color: color_s4};

endmodule

`default_nettype wire

// ===== rtl/tilemap_pixel_generator_core.sv =====
`default_nettype none

// Channel  Role    Payload                                         Transfer
// cmd      sink    action, ram_address, write_data, pixel_x/y     valid & ready
// pixel    source  palette_index, red, green, blue                 valid & ready
//
// One command per cycle while the output is not held; a render's pixel goes
// through capture -> tile code read -> pattern read -> PROM read -> output.
// Writes give no pixel and take effect at the stage where renders read.
// Reset clears the valid bits only; RAM and PROM contents are undefined.
// A held output stalls the whole pipeline; cmd.ready follows it directly.

module tilemap_pixel_generator_core (
	input wire logic    clk,
	input wire logic    arst_n,
	tpg_stream_if.sink   cmd,
	tpg_stream_if.source pixel
);
	import tpg_pkg::*;

	logic       adv;
	map_stage_t map_s2;
	pat_stage_t pat_s3;
	pal_stage_t pal_s4;
	logic       pixel_valid_q;
	pixel_t     pixel_q;

	// Whole pipeline moves unless the result is held
	assign adv       = !pixel_valid_q || pixel.ready;
	assign cmd.ready = adv;

	tpg_map_fetch u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (cmd.valid),
		.in_cmd   (cmd.payload),
		.map_s2   (map_s2)
	);

	tpg_pattern_fetch u_pattern (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.map_s2 (map_s2),
		.pat_s3 (pat_s3)
	);

	tpg_palette u_palette (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.pat_s3 (pat_s3),
		.pal_s4 (pal_s4)
	);

	// Output register with resistor DAC weighting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pixel_valid_q <= 1'b0;
		else if (adv)
			pixel_valid_q <= pal_s4.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_q.palette_index <= pal_s4.palette_index;
			pixel_q.red           <= level3(pal_s4.color[2:0]);
			pixel_q.green         <= level3(pal_s4.color[5:3]);
			pixel_q.blue          <= level3({pal_s4.color[7:6], 1'b0});
		end
	end

	assign pixel.valid   = pixel_valid_q;
	assign pixel.payload = pixel_q;

	// A render that advances through every stage reaches the output as a valid pixel
	a_render_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.payload.action == ACT_RENDER)
		##1 adv ##1 adv ##1 adv ##1 adv |=> pixel.valid)
		else $error("render did not reach output");

	// A new pixel appears only from a render in the palette stage
	a_pixel_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pixel.valid) |-> $past(pal_s4.valid))
		else $error("pixel valid without a render");

endmodule

`default_nettype wire
